>>> rtl/core/stbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and constants for the sorted table search unit
// Opcodes, fixed field widths, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // fixed field widths
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  // table depth, tied to the index and count widths
  localparam int DEPTH = 1024;

  // item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic write_entry;  // store the input word at its index
    logic load_search;  // latch key, set low/high bounds
    logic issue_read;   // register midpoint, read table
    logic step;         // compare read word, move a bound or stage a hit
    logic miss;         // stage a not-found result
    logic load_out;     // move staged result to the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_search;  // input item is a search
    logic range_ok;   // low <= high
    logic hit;        // read word equals the key
    logic out_free;   // output register can take a result this cycle
  } ctrl_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/stbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_ctrl: search sequencer
// Accepts items, steps the probe loop and hands results to the output stage.
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  stbs_pkg::ctrl_sts_t  sts,
  output stbs_pkg::ctrl_cmd_t  cmd
);
  import stbs_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.op_search) begin
            cmd.load_search = 1'b1;
            state_next      = ST_PROBE;
          end else begin
            cmd.write_entry = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (sts.range_ok) begin
          cmd.issue_read = 1'b1;
          state_next     = ST_COMPARE;
        end else begin
          cmd.miss   = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_COMPARE: begin
        cmd.step   = 1'b1;
        state_next = sts.hit ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/stbs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_datapath: table memory, search bounds and result registers
// Holds the entry table, the count register, the low/high/mid pointers and
// the output register with its valid flag.
// ----------------------------------------------------------------------------
module stbs_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_wr_en,
  input  wire  [stbs_pkg::COUNT_W-1:0]        cfg_wr_data,
  input  wire                                 opcode,
  input  wire  [stbs_pkg::INDEX_W-1:0]        entry_index,
  input  wire  signed [VALUE_WIDTH-1:0]       word_value,
  input  stbs_pkg::ctrl_cmd_t                 cmd,
  output stbs_pkg::ctrl_sts_t                 sts,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                found,
  output logic [stbs_pkg::INDEX_W-1:0]        match_index
);
  import stbs_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PTR_W = ((AW > COUNT_W) ? AW : COUNT_W) + 2;

  logic        [VALUE_WIDTH-1:0] table_mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic signed [VALUE_WIDTH-1:0] key;
  logic        [COUNT_W-1:0]     entry_count;
  logic signed [PTR_W-1:0]       low;
  logic signed [PTR_W-1:0]       high;
  logic signed [PTR_W-1:0]       mid;
  logic signed [PTR_W-1:0]       mid_calc;
  logic signed [PTR_W:0]         mid_sum;
  logic signed [PTR_W-1:0]       count_clamp;
  logic        [31:0]            idx_ext;
  logic                          idx_ok;
  logic                          res_found;
  logic        [INDEX_W-1:0]     res_index;

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  // write address check and count clamp to the table depth
  assign idx_ext = 32'(entry_index);
  assign idx_ok  = idx_ext < 32'(DEPTH);

  always_comb begin
    if (32'(entry_count) > 32'(DEPTH)) begin
      count_clamp = PTR_W'(DEPTH);
    end else begin
      count_clamp = PTR_W'(entry_count);
    end
  end

  // midpoint, both bounds are non-negative whenever a probe is issued
  assign mid_sum  = (PTR_W + 1)'(low) + (PTR_W + 1)'(high);
  assign mid_calc = PTR_W'(mid_sum >>> 1);

  // table memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.write_entry && idx_ok) begin
      table_mem[idx_ext[AW-1:0]] <= word_value;
    end
    if (cmd.issue_read) begin
      rd_data <= table_mem[mid_calc[AW-1:0]];
    end
  end

  // search pointers and staged result
  always_ff @(posedge clk) begin
    if (cmd.load_search) begin
      key  <= word_value;
      low  <= '0;
      high <= count_clamp - PTR_W'(1);
    end
    if (cmd.issue_read) begin
      mid <= mid_calc;
    end
    if (cmd.step) begin
      if (rd_data == key) begin
        res_found <= 1'b1;
        res_index <= mid[INDEX_W-1:0];
      end else if (rd_data < key) begin
        low <= mid + PTR_W'(1);
      end else begin
        high <= mid - PTR_W'(1);
      end
    end
    if (cmd.miss) begin
      res_found <= 1'b0;
      res_index <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found       <= res_found;
      match_index <= res_index;
    end
  end

  // status to the controller
  assign sts.op_search = (opcode == OP_SEARCH);
  assign sts.range_ok  = (low <= high);
  assign sts.hit       = (rd_data == key);
  assign sts.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

>>> rtl/core/sorted_table_binary_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit: binary search over a table of signed words
// Write items fill the table; search items probe entries 0..entry_count-1.
// ----------------------------------------------------------------------------
// A write item is taken and the block stays ready for the next item.
// A search is accepted, then runs its probes, each a registered table
// read followed by a compare; a match, or low passing high, ends it and
// the result is loaded once the output register is free. Over a full
// 1024-entry table that is at most 11 probes. One search is in flight at a
// time; the output register holds a finished result until it is taken
// while the next item is accepted. An entry_count above DEPTH is
// treated as DEPTH, and writes to an index of DEPTH or more are dropped.
module sorted_table_binary_search_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_wr_en,
  input  wire  [stbs_pkg::COUNT_W-1:0]     cfg_wr_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              opcode,
  input  wire  [stbs_pkg::INDEX_W-1:0]     entry_index,
  input  wire  signed [VALUE_WIDTH-1:0]    word_value,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             found,
  output logic [stbs_pkg::INDEX_W-1:0]     match_index
);
  import stbs_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stbs_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .opcode      (opcode),
    .entry_index (entry_index),
    .word_value  (word_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .match_index (match_index)
  );

  // a miss always reports index zero
  a_miss_index_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_index == '0)
    else $error("not-found result with nonzero index");

  // a result load always presents a transfer on the next cycle
  a_load_shows_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load without output valid");

  // once a search starts, the input stops being ready
  a_search_blocks_input : assert property (@(posedge clk) disable iff (rst)
    cmd.load_search |=> !in_ready)
    else $error("input accepted during a search");

  // a probe read is only issued inside the search bounds
  a_read_in_range : assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |-> sts.range_ok && !in_ready)
    else $error("probe issued outside the search bounds");

endmodule
`default_nettype wire

>>> bench/search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_checker: result predictor and comparator for the binary search unit
// Watches the register port and both channels, keeps its own copy of the
// table and of entry_count, and works out the answer of every search
// transfer. Each result transfer is compared field by field with the oldest
// answer still waiting.
// ----------------------------------------------------------------------------
module search_checker #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_wr_en,
  input  wire [stbs_pkg::COUNT_W-1:0]    cfg_wr_data,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  wire                            opcode,
  input  wire [stbs_pkg::INDEX_W-1:0]    entry_index,
  input  wire signed [VALUE_WIDTH-1:0]   word_value,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  wire                            found,
  input  wire [stbs_pkg::INDEX_W-1:0]    match_index,
  output int                             pending_results,
  output int                             fail_count
);
  import stbs_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] index;
  } search_answer_t;

  logic signed [VALUE_WIDTH-1:0] entry_words [0:DEPTH-1];
  logic [COUNT_W-1:0]            entry_count = '0;
  search_answer_t                expected_answers [$];
  int                            mismatches = 0;

  // probe sequence of the search: midpoint, then move one bound
  function automatic search_answer_t lookup_key(input logic signed [VALUE_WIDTH-1:0] key);
    search_answer_t answer;
    int             lo;
    int             hi;
    int             mid;
    bit             done;
    answer = '0;
    lo     = 0;
    hi     = (entry_count > DEPTH) ? DEPTH - 1 : int'(entry_count) - 1;
    done   = 1'b0;
    while (!done && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (entry_words[mid] == key) begin
        answer.hit   = 1'b1;
        answer.index = mid[INDEX_W-1:0];
        done         = 1'b1;
      end else if (entry_words[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return answer;
  endfunction

  always @(posedge clk) begin : monitor
    search_answer_t want;
    if (rst) begin
      entry_count = '0;
      expected_answers.delete();
    end else begin
      if (cfg_wr_en) begin
        entry_count = cfg_wr_data;
      end
      // result side first, so a search taken at this edge cannot match it
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("checker: unexpected result found=%0d index=%0d at %0t",
                     found, match_index, $realtime);
          end
        end else begin
          want = expected_answers.pop_front();
          if (found !== want.hit || match_index !== want.index) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("checker: mismatch at %0t: want %0d/%0d got %0d/%0d",
                       $realtime, want.hit, want.index, found, match_index);
            end
          end
        end
      end
      // input transfer: writes update the table copy, searches queue an answer
      if (in_valid && in_ready) begin
        if (opcode == OP_WRITE) begin
          if (entry_index < DEPTH) begin
            entry_words[entry_index] = word_value;
          end
        end else begin
          expected_answers.push_back(lookup_key(word_value));
        end
      end
    end
    pending_results <= expected_answers.size();
    fail_count      <= mismatches;
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the sorted table binary search unit
// Directed writes and searches over the signed extremes, an empty table, a
// repeated entry and an out-of-order entry; then a sorted fill of the whole
// table and random phases at varied entry counts with random idling on both
// channels. Checking is done by the search_checker instance.
// ----------------------------------------------------------------------------
module tb_top;
  import stbs_pkg::*;

  localparam int TABLE_DEPTH   = 1024;
  localparam int MAX_COUNT     = (1 << COUNT_W) - 1;
  localparam int RANDOM_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic               opcode      = OP_WRITE;
  logic [INDEX_W-1:0] entry_index = '0;
  logic signed [31:0] word_value  = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               found;
  logic [INDEX_W-1:0] match_index;
  int                 pending_results;
  int                 fail_count;

  // table contents as written, used only to aim searches and writes
  logic signed [31:0] shadow [0:TABLE_DEPTH-1];
  int                 live_count   = 0;
  int                 tx_calm      = 0;
  int                 rx_calm      = 0;
  int                 rx_hold      = 0;
  int                 stall_cycles = 0;

  always #5 clk = ~clk;

  sorted_table_binary_search_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .entry_index (entry_index),
    .word_value  (word_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .match_index (match_index)
  );

  search_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .entry_index     (entry_index),
    .word_value      (word_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .match_index     (match_index),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  // idle cycles before a transfer; occasional runs with no idling at all
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(8, 40);
    end
    return $urandom_range(0, 13);
  endfunction

  // search value: mostly a present entry, else a neighbor, an extreme or noise
  function automatic logic signed [31:0] pick_key();
    int sel;
    int pos;
    sel = $urandom_range(0, 9);
    pos = (live_count > 0) ? $urandom_range(0, live_count - 1) : 0;
    if (live_count == 0 || sel == 9) return $urandom;
    if (sel == 8) return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
    if (sel == 7) return shadow[pos] + 1;
    if (sel == 6) return shadow[pos] - 1;
    return shadow[pos];
  endfunction

  // write value that keeps the entry between its neighbors
  function automatic logic signed [31:0] fitting_value(input int idx);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    longint             span;
    longint unsigned    draw;
    lo = (idx > 0) ? shadow[idx-1] : WORD_MIN;
    hi = (idx < TABLE_DEPTH - 1) ? shadow[idx+1] : WORD_MAX;
    if (lo > hi) return $urandom;  // neighborhood already out of order
    span = longint'(hi) - longint'(lo) + 1;
    draw = {$urandom, $urandom};
    return 32'(lo + (draw % span));
  endfunction

  // one input transfer, after a random number of idle cycles
  task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic signed [31:0] val);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    word_value  <= val;
    do @(posedge clk); while (!in_ready);
    if (op == OP_WRITE) shadow[idx] = val;
  endtask

  // stop offering and wait until every search has answered
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // entry_count is only written with the block idle
  task automatic set_entry_count(input int n);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n[COUNT_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    live_count = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
  endtask

  // result side: random stalls, plus one long hold when requested
  initial begin : result_sink
    int gap;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end else begin
        gap = draw_gap(rx_calm);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int     n_sent;
    int     phase;
    int     len;
    int     kind;
    int     idx;
    int     pause_at;
    longint level;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: nothing can match
    set_entry_count(0);
    send_item(OP_SEARCH, '1, WORD_MIN);
    send_item(OP_SEARCH, '0, WORD_MAX);

    // short ascending run across the signed extremes, top value repeated
    send_item(OP_WRITE, 0, WORD_MIN);
    send_item(OP_WRITE, 1, -1);
    send_item(OP_WRITE, 2, 0);
    send_item(OP_WRITE, 3, 1);
    send_item(OP_WRITE, 4, WORD_MAX);
    send_item(OP_WRITE, 5, WORD_MAX);
    set_entry_count(5);
    send_item(OP_SEARCH, 0, WORD_MIN);
    send_item(OP_SEARCH, 0, -1);
    send_item(OP_SEARCH, 0, 0);
    send_item(OP_SEARCH, 0, 1);
    send_item(OP_SEARCH, 0, WORD_MAX);
    send_item(OP_SEARCH, 0, 2);
    send_item(OP_SEARCH, 0, -2);

    // equal entries: first one met by a probe wins
    set_entry_count(6);
    send_item(OP_SEARCH, 0, WORD_MAX);

    // out-of-order entry in the middle
    send_item(OP_WRITE, 2, 7);
    send_item(OP_SEARCH, 0, 7);
    send_item(OP_SEARCH, 0, 0);

    // sorted fill of the whole table, extremes at both ends, some repeats
    level = WORD_MIN;
    for (idx = 0; idx < TABLE_DEPTH; idx++) begin
      if (idx == TABLE_DEPTH - 1) level = WORD_MAX;
      send_item(OP_WRITE, idx[INDEX_W-1:0], level[31:0]);
      if ($urandom_range(0, 7) != 0) level += $urandom_range(1, 8_000_000);
      if (level > WORD_MAX) level = WORD_MAX;
    end

    // full table, count clamped above depth, single entry
    set_entry_count(TABLE_DEPTH);
    send_item(OP_SEARCH, 0, WORD_MIN);
    send_item(OP_SEARCH, 0, WORD_MAX);
    send_item(OP_SEARCH, 0, shadow[TABLE_DEPTH/2]);
    send_item(OP_SEARCH, 0, shadow[1] + 1);
    set_entry_count(MAX_COUNT);
    send_item(OP_SEARCH, 0, shadow[TABLE_DEPTH-2]);
    send_item(OP_SEARCH, 0, $urandom);
    set_entry_count(1);
    send_item(OP_SEARCH, 0, WORD_MIN);
    send_item(OP_SEARCH, 0, shadow[1]);

    // random phases, each at its own entry count
    n_sent = 0;
    phase  = 0;
    while (n_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0:       set_entry_count(0);
        1:       set_entry_count(TABLE_DEPTH);
        2:       set_entry_count($urandom_range(TABLE_DEPTH + 1, MAX_COUNT));
        3:       set_entry_count($urandom_range(1, TABLE_DEPTH - 1));
        default: set_entry_count($urandom_range(1, 64));
      endcase
      // long result-side hold while items keep coming
      if (phase == 2) rx_hold = LONG_HOLD;
      len      = $urandom_range(10, 40);
      pause_at = (phase % 4 == 1) ? len / 2 : -1;
      for (int k = 0; k < len; k++) begin
        if (k == pause_at) wait_drained();
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
          send_item(OP_SEARCH, INDEX_W'($urandom), pick_key());
        end else if (kind < 17) begin
          idx = (live_count > 0) ? $urandom_range(0, live_count - 1)
                                 : $urandom_range(0, TABLE_DEPTH - 1);
          send_item(OP_WRITE, idx[INDEX_W-1:0], fitting_value(idx));
        end else begin
          send_item(OP_WRITE, INDEX_W'($urandom), $urandom);
        end
        n_sent++;
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
